// File: rtl/frb_pkg.sv
package frb_pkg;

  localparam int unsigned HALF_SPAN    = 32'h7FFF_FFFF;
  localparam int unsigned SERIAL_LIMIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_TAKE = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_LATE      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_DELIVERED = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } fsm_state_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic [31:0] seq;
    logic [15:0] block;
  } rkey_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input item, do source lookup / tick
    logic scan_init; // clear scan candidates
    logic scan_step; // examine one entry
    logic finish;    // resolve result of add or take
  } frb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic needs_scan; // add passed early checks, or take
    logic scan_last;  // pending read holds the final entry
  } frb_stat_t;

  function automatic logic serial_before(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] limit);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && (d < limit);
  endfunction

  function automatic logic key_less(input rkey_t a, input rkey_t b);
    if (serial_before(a.epoch, b.epoch, HALF_SPAN)) return 1'b1;
    if (a.epoch == b.epoch) begin
      if (serial_before(a.seq, b.seq, HALF_SPAN)) return 1'b1;
      if (a.seq == b.seq && a.block < b.block) return 1'b1;
    end
    return 1'b0;
  endfunction

endpackage

// File: rtl/frb_ctrl.sv
module frb_ctrl
  import frb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_fire,
  input  frb_stat_t stat,
  output frb_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Load step has resolved the early checks; scan if needed
        if (stat.needs_scan) begin
          cmd.scan_init = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // finish the scan in the same cycle as its last step
    if (state == S_SCAN && stat.scan_last) cmd.finish = 1'b1;
  end

endmodule

// File: rtl/frb_datapath.sv
module frb_datapath
  import frb_pkg::*;
#(
  parameter int QUEUE_DEPTH     = 64,
  parameter int SOURCE_SLOTS    = 4,
  parameter int MAX_FRAME_BYTES = 8192
)(
  input  logic        clk,
  input  logic        rst,
  input  frb_cmd_t    cmd,
  output frb_stat_t   stat,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic [1:0]  action,
  input  logic [7:0]  source_id,
  input  logic [31:0] sequence_number,
  input  logic [15:0] block_number,
  input  logic [15:0] frame_handle,
  input  logic [13:0] byte_count,
  output logic [2:0]  status,
  output logic [31:0] out_sequence,
  output logic [15:0] out_block,
  output logic [15:0] out_handle,
  output logic [13:0] out_bytes
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = $clog2(SOURCE_SLOTS);

  // configuration
  logic [19:0] reveal_delay;
  logic [19:0] purge_delay;

  // entry store: keys, reveal times and descriptors in memory, valid in flops
  logic [QUEUE_DEPTH-1:0] ent_valid;
  rkey_t       mem_key  [QUEUE_DEPTH];
  logic [31:0] mem_rev  [QUEUE_DEPTH];
  logic [29:0] mem_desc [QUEUE_DEPTH];

  logic [SOURCE_SLOTS-1:0] src_valid;
  logic [7:0]  src_id    [SOURCE_SLOTS];
  logic [31:0] src_epoch [SOURCE_SLOTS];
  logic [31:0] next_epoch;
  logic [1:0]  pg_valid;
  logic [31:0] pg_epoch [2];
  logic [31:0] pg_due   [2];
  rkey_t       last_key;
  logic        released;
  logic [31:0] time_now;

  // item registers
  action_t     act;
  rkey_t       key;
  logic [29:0] desc;
  logic        early_done;

  // scan
  logic [QW:0]   scan_idx;   // counts one past the pending read index
  logic [QW-1:0] rd_addr;
  logic          rd_pending;
  logic [QW-1:0] rd_idx;
  rkey_t         rd_key;
  logic [31:0]   rd_rev;
  logic [29:0]   rd_desc;
  logic          dup_found;
  logic          free_found;
  logic [QW-1:0] free_idx;
  logic          best_found;
  logic [QW-1:0] best_idx;
  rkey_t         best_key;
  logic [31:0]   best_rev;
  logic [29:0]   best_desc;

  logic [31:0] out_seq_r;
  logic [15:0] out_blk_r, out_hdl_r;
  logic [13:0] out_byt_r;
  status_t     st;

  // source lookup
  logic          src_hit;
  logic [SW-1:0] hit_idx;
  logic          src_free;
  logic [SW-1:0] free_src;
  logic [$clog2(SOURCE_SLOTS+1)-1:0] src_count;
  rkey_t         key_now;

  always_comb begin
    src_hit = 1'b0; hit_idx = '0; src_free = 1'b0; free_src = '0; src_count = '0;
    for (int i = 0; i < SOURCE_SLOTS; i++) begin
      if (src_valid[i]) begin
        src_count = src_count + 1'b1;
        if (src_id[i] == source_id) begin
          src_hit = 1'b1;
          hit_idx = SW'(i);
        end
      end else if (!src_free) begin
        src_free = 1'b1;
        free_src = SW'(i);
      end
    end
    key_now.epoch = src_hit ? src_epoch[hit_idx] : next_epoch;
    key_now.seq   = sequence_number;
    key_now.block = block_number;
  end

  function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
    logic [31:0] d;
    d = now - t;
    return d < SERIAL_LIMIT;
  endfunction

  assign stat.needs_scan = !early_done;
  assign stat.scan_last  = rd_pending && (scan_idx == (QW+1)'(QUEUE_DEPTH));
  assign rd_addr = scan_idx[QW-1:0];

  // memory reads, registered
  always_ff @(posedge clk) begin
    rd_key  <= mem_key[rd_addr];
    rd_rev  <= mem_rev[rd_addr];
    rd_desc <= mem_desc[rd_addr];
    rd_idx  <= rd_addr;
  end

  logic scan_done;
  assign scan_done = cmd.finish;

  // memory writes
  logic          mem_we;
  logic [QW-1:0] mem_wa;
  assign mem_we = scan_done && act == ACT_ADD && !dup_found
                  && !(rd_pending && ent_valid[rd_idx] && rd_key == key)
                  && (free_found || (rd_pending && !ent_valid[rd_idx]));
  assign mem_wa = free_found ? free_idx : rd_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[mem_wa]  <= key;
      mem_rev[mem_wa]  <= time_now + 32'(reveal_delay);
      mem_desc[mem_wa] <= desc;
    end
  end

  // per-step candidate evaluation of the pending read
  logic          l_dup, l_free, l_best;
  logic [QW-1:0] l_free_idx, l_best_idx;
  rkey_t         l_best_key;
  logic [31:0]   l_best_rev;
  logic [29:0]   l_best_desc;

  always_comb begin
    l_dup = dup_found; l_free = free_found; l_free_idx = free_idx;
    l_best = best_found; l_best_idx = best_idx; l_best_key = best_key;
    l_best_rev = best_rev; l_best_desc = best_desc;
    if (rd_pending) begin
      if (ent_valid[rd_idx]) begin
        if (rd_key == key) l_dup = 1'b1;
        if (!best_found || key_less(rd_key, best_key)) begin
          l_best = 1'b1; l_best_idx = rd_idx; l_best_key = rd_key;
          l_best_rev = rd_rev; l_best_desc = rd_desc;
        end
      end else if (!free_found) begin
        l_free = 1'b1; l_free_idx = rd_idx;
      end
    end
  end

  logic deliver;
  assign deliver = scan_done && act == ACT_TAKE && l_best && reached(time_now, l_best_rev);

  always_ff @(posedge clk) begin
    if (rst) begin
      reveal_delay <= 20'd1000;
      purge_delay  <= 20'd300000;
      ent_valid    <= '0;
      src_valid    <= '0;
      next_epoch   <= '0;
      pg_valid     <= '0;
      last_key     <= '0;
      released     <= 1'b0;
      time_now     <= '0;
      rd_pending   <= 1'b0;
      scan_idx     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) purge_delay <= cfg_data;
        else reveal_delay <= cfg_data;
      end

      if (cmd.load) begin
        act  <= action_t'(action);
        desc <= {byte_count, frame_handle};
        early_done <= 1'b1;
        st <= ST_NONE;
        out_seq_r <= '0; out_blk_r <= '0; out_hdl_r <= '0; out_byt_r <= '0;
        unique case (action_t'(action))
          ACT_ADD: begin
            key <= key_now;
            if (!src_hit && !src_free) begin
              st <= ST_FULL;
            end else begin
              if (!src_hit) begin
                src_valid[free_src] <= 1'b1;
                src_id[free_src]    <= source_id;
                src_epoch[free_src] <= next_epoch;
                next_epoch <= next_epoch + 32'd1;
                if (src_count != '0) begin
                  // replace a free purge slot, else the serially older one
                  if (!pg_valid[0]) begin
                    pg_valid[0] <= 1'b1; pg_epoch[0] <= next_epoch;
                    pg_due[0] <= time_now + 32'(purge_delay);
                  end else if (!pg_valid[1] ||
                               serial_before(pg_epoch[1], pg_epoch[0], SERIAL_LIMIT)) begin
                    pg_valid[1] <= 1'b1; pg_epoch[1] <= next_epoch;
                    pg_due[1] <= time_now + 32'(purge_delay);
                  end else begin
                    pg_epoch[0] <= next_epoch;
                    pg_due[0] <= time_now + 32'(purge_delay);
                  end
                end
              end
              if (released && (key_less(key_now, last_key) || key_now == last_key))
                st <= ST_LATE;
              else if (32'(byte_count) > 32'(MAX_FRAME_BYTES))
                st <= ST_FULL;
              else
                early_done <= 1'b0;
            end
          end
          ACT_TICK: begin
            // purges check the advanced time
            time_now <= time_now + 32'd1;
            for (int p = 0; p < 2; p++) begin
              if (pg_valid[p] && reached(time_now + 32'd1, pg_due[p])) begin
                for (int s = 0; s < SOURCE_SLOTS; s++)
                  if (src_valid[s] && serial_before(src_epoch[s], pg_epoch[p], SERIAL_LIMIT))
                    src_valid[s] <= 1'b0;
                pg_valid[p] <= 1'b0;
              end
            end
          end
          ACT_TAKE: early_done <= 1'b0;
          default: ;
        endcase
      end

      if (cmd.scan_init) begin
        scan_idx   <= '0;
        rd_pending <= 1'b0;
        dup_found  <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
      end else if (cmd.scan_step) begin
        dup_found <= l_dup; free_found <= l_free; free_idx <= l_free_idx;
        best_found <= l_best; best_idx <= l_best_idx; best_key <= l_best_key;
        best_rev <= l_best_rev; best_desc <= l_best_desc;
        rd_pending <= 1'b1;
        scan_idx <= scan_idx + 1'b1;
        if (stat.scan_last) begin
          rd_pending <= 1'b0;
          // resolve
          if (act == ACT_ADD) begin
            if (l_dup) st <= ST_DUPLICATE;
            else if (!l_free) st <= ST_FULL;
            else begin
              st <= ST_ACCEPTED;
              ent_valid[l_free_idx] <= 1'b1;
            end
          end else if (deliver) begin
            st <= ST_DELIVERED;
            out_seq_r <= l_best_key.seq;
            out_blk_r <= l_best_key.block;
            out_hdl_r <= l_best_desc[15:0];
            out_byt_r <= l_best_desc[29:16];
            last_key  <= l_best_key;
            released  <= 1'b1;
            ent_valid[l_best_idx] <= 1'b0;
          end
        end
      end
    end
  end

  assign status       = st;
  assign out_sequence = out_seq_r;
  assign out_block    = out_blk_r;
  assign out_handle   = out_hdl_r;
  assign out_bytes    = out_byt_r;

endmodule

// File: rtl/frame_reorder_buffer.sv
// Channel | Dir | tdata fields (low bit up)                                 | tuser
// s_axis  | in  | source_id, sequence_number, block_number, frame_handle,    | action
//         |     | byte_count (86 bits, padded to 88)                         |
// m_axis  | out | out_sequence, out_block, out_handle, out_bytes (78 -> 80)  | status
// cfg     | in  | cfg_we, cfg_index (0 reveal delay, 1 purge delay), cfg_data |
//
// Timing: a tick, an unused action or an early-rejected add skips the scan and goes
//   from the load step straight to the result; an add or take that searches the
//   store scans it with a one-entry-per-cycle read of the entry memory.
// One item at a time: s_axis_tready is low from accept until the result is taken.
// Reset: synchronous, rst high; clears valid bits, source table, purges, time.
// A stalled m_axis holds the result and the block takes no new item.
module frame_reorder_buffer
  import frb_pkg::*;
#(
  parameter int QUEUE_DEPTH     = 64,
  parameter int SOURCE_SLOTS    = 4,
  parameter int MAX_FRAME_BYTES = 8192
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // source_id[7:0], sequence_number[39:8], block_number[55:40],
  // frame_handle[71:56], byte_count[85:72], zero pad [87:86]
  input  logic [87:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_sequence[31:0], out_block[47:32], out_handle[63:48], out_bytes[77:64],
  // zero pad [79:78]
  output logic [79:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  frb_cmd_t  cmd;
  frb_stat_t stat;
  logic      busy;
  logic      in_fire, out_fire;
  logic [31:0] o_seq;
  logic [15:0] o_blk, o_hdl;
  logic [13:0] o_byt;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  frb_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .stat, .cmd, .busy,
    .out_valid(m_axis_tvalid)
  );

  frb_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .SOURCE_SLOTS(SOURCE_SLOTS),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .action(s_axis_tuser),
    .source_id(s_axis_tdata[7:0]),
    .sequence_number(s_axis_tdata[39:8]),
    .block_number(s_axis_tdata[55:40]),
    .frame_handle(s_axis_tdata[71:56]),
    .byte_count(s_axis_tdata[85:72]),
    .status(m_axis_tuser),
    .out_sequence(o_seq), .out_block(o_blk), .out_handle(o_hdl), .out_bytes(o_byt)
  );

  assign m_axis_tdata = {2'b00, o_byt, o_hdl, o_blk, o_seq};

endmodule

// File: rtl/frb_checker.sv
module frb_checker
  import frb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // never accept while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");

  // no result in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result too early after accept");

  // payload zero unless delivered
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_DELIVERED) |-> m_axis_tdata == '0)
    else $error("payload set on non-delivery");

  // status in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= ST_NONE)
    else $error("bad status");

  // a result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped under stall");

endmodule

bind frame_reorder_buffer frb_checker u_frb_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);

// File: tb/sv/frame_reorder_buffer_test.sv
`timescale 1ns / 100ps

module frame_reorder_buffer_test;
  import frb_pkg::*;

  localparam int DEPTH      = 64;
  localparam int SRC_SLOTS  = 4;
  localparam int MAX_BYTES  = 8192;
  localparam int DRAIN_WAIT = DEPTH + 16;
  // Slowest item: scan, worst sender gap and worst receiver stall, with margin.
  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [19:0] cfg_data;

  frame_reorder_buffer dut (.*);

  typedef struct packed {
    status_t     status;
    logic [31:0] seq;
    logic [15:0] blk;
    logic [15:0] hnd;
    logic [13:0] nbytes;
  } outcome_t;

  outcome_t pending_outcomes[$];
  int       errors;
  bit       quiet;         // no idling on either side while set
  int       idle_cycles;
  int       stall_left;
  logic [31:0] seq_cursor;

  // Shadow of the buffer state
  logic        ent_v[DEPTH];
  rkey_t       ent_k[DEPTH];
  logic [31:0] ent_reveal[DEPTH];
  logic [15:0] ent_hnd[DEPTH];
  logic [13:0] ent_bytes[DEPTH];
  logic        src_v[SRC_SLOTS];
  logic [7:0]  src_name[SRC_SLOTS];
  logic [31:0] src_epoch[SRC_SLOTS];
  logic        purge_v[2];
  logic [31:0] purge_epoch[2];
  logic [31:0] purge_due[2];
  logic [31:0] epoch_next;
  rkey_t       last_out_key;
  logic        any_released;
  logic [31:0] ticks;
  logic [19:0] reveal_delay;
  logic [19:0] purge_delay;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Ordering helpers
  // ---------------------------------------------------------------------------

  // a strictly ahead of b on the serial circle, within the given window
  function automatic bit serially_ahead(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
    logic [31:0] diff;
    diff = b - a;
    return (diff != 0) && (diff < lim);
  endfunction

  function automatic bit key_precedes(rkey_t a, rkey_t b);
    bit res;
    res = 1'b0;
    if (serially_ahead(a.epoch, b.epoch, HALF_SPAN)) res = 1'b1;
    else if (a.epoch == b.epoch) begin
      if (serially_ahead(a.seq, b.seq, HALF_SPAN)) res = 1'b1;
      else if (a.seq == b.seq && a.block < b.block) res = 1'b1;
    end
    return res;
  endfunction

  function automatic bit tick_reached(logic [31:0] t);
    logic [31:0] d;
    d = ticks - t;
    return d < SERIAL_LIMIT;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    for (int i = 0; i < DEPTH; i++) ent_v[i] = 1'b0;
    for (int i = 0; i < SRC_SLOTS; i++) src_v[i] = 1'b0;
    purge_v[0] = 1'b0;
    purge_v[1] = 1'b0;
    epoch_next = '0;
    last_out_key = '0;
    any_released = 1'b0;
    ticks = '0;
    reveal_delay = 20'd1000;
    purge_delay = 20'd300000;
  endfunction

  function automatic void book_purge(logic [31:0] ep);
    int p;
    p = -1;
    if (!purge_v[0]) p = 0;
    else if (!purge_v[1]) p = 1;
    else p = serially_ahead(purge_epoch[1], purge_epoch[0], SERIAL_LIMIT) ? 1 : 0;
    purge_v[p] = 1'b1;
    purge_epoch[p] = ep;
    purge_due[p] = ticks + purge_delay;
  endfunction

  function automatic status_t admit_frame(logic [7:0] src, logic [31:0] seq,
                                          logic [15:0] blk, logic [15:0] hnd,
                                          logic [13:0] nb);
    int    hit, hole, used;
    rkey_t k;
    hit = -1; hole = -1; used = 0;
    for (int i = 0; i < SRC_SLOTS; i++) begin
      if (src_v[i]) begin
        used++;
        if (src_name[i] == src) hit = i;
      end else if (hole < 0) hole = i;
    end
    // Source lookup stands even when the frame is later refused.
    if (hit >= 0) k.epoch = src_epoch[hit];
    else begin
      if (hole < 0) return ST_FULL;
      src_v[hole] = 1'b1;
      src_name[hole] = src;
      src_epoch[hole] = epoch_next;
      if (used + 1 > 1) book_purge(epoch_next);
      k.epoch = epoch_next;
      epoch_next++;
    end
    k.seq = seq;
    k.block = blk;
    if (any_released && (key_precedes(k, last_out_key) || k == last_out_key)) return ST_LATE;
    if (nb > MAX_BYTES) return ST_FULL;
    hole = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (ent_v[i]) begin
        if (ent_k[i] == k) return ST_DUPLICATE;
      end else if (hole < 0) hole = i;
    end
    if (hole < 0) return ST_FULL;
    ent_v[hole] = 1'b1;
    ent_k[hole] = k;
    ent_reveal[hole] = ticks + reveal_delay;
    ent_hnd[hole] = hnd;
    ent_bytes[hole] = nb;
    return ST_ACCEPTED;
  endfunction

  function automatic void advance_tick();
    ticks++;
    for (int p = 0; p < 2; p++) begin
      if (purge_v[p] && tick_reached(purge_due[p])) begin
        for (int s = 0; s < SRC_SLOTS; s++)
          if (src_v[s] && serially_ahead(src_epoch[s], purge_epoch[p], SERIAL_LIMIT))
            src_v[s] = 1'b0;
        purge_v[p] = 1'b0;
      end
    end
  endfunction

  function automatic outcome_t release_oldest();
    outcome_t r;
    int best;
    r = '0;
    r.status = ST_NONE;
    best = -1;
    for (int i = 0; i < DEPTH; i++)
      if (ent_v[i] && (best < 0 || key_precedes(ent_k[i], ent_k[best]))) best = i;
    if (best >= 0 && tick_reached(ent_reveal[best])) begin
      r.status = ST_DELIVERED;
      r.seq = ent_k[best].seq;
      r.blk = ent_k[best].block;
      r.hnd = ent_hnd[best];
      r.nbytes = ent_bytes[best];
      last_out_key = ent_k[best];
      any_released = 1'b1;
      ent_v[best] = 1'b0;
    end
    return r;
  endfunction

  function automatic outcome_t predict_item(action_t act, logic [7:0] src, logic [31:0] seq,
                                            logic [15:0] blk, logic [15:0] hnd,
                                            logic [13:0] nb);
    outcome_t r;
    r = '0;
    r.status = ST_NONE;
    case (act)
      ACT_ADD:  r.status = admit_frame(src, seq, blk, hnd, nb);
      ACT_TICK: advance_tick();
      ACT_TAKE: r = release_oldest();
      default:  ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one item; tvalid is left high so a back-to-back item never drops it.
  task automatic send_item(action_t act, logic [7:0] src = 0, logic [31:0] seq = 0,
                           logic [15:0] blk = 0, logic [15:0] hnd = 0,
                           logic [13:0] nb = 0);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {2'b00, nb, hnd, blk, seq, src};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_outcomes.push_back(predict_item(act, src, seq, blk, hnd, nb));
  endtask

  // Drop tvalid and wait until every outstanding result has been checked.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == 1'b0) reveal_delay = val;
    else purge_delay = val;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) report("unexpected result", m_axis_tuser, 0);
      else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser != want.status) report("status", m_axis_tuser, want.status);
        if (m_axis_tdata[31:0] != want.seq) report("out_sequence", m_axis_tdata[31:0], want.seq);
        if (m_axis_tdata[47:32] != want.blk) report("out_block", m_axis_tdata[47:32], want.blk);
        if (m_axis_tdata[63:48] != want.hnd) report("out_handle", m_axis_tdata[63:48], want.hnd);
        if (m_axis_tdata[77:64] != want.nbytes)
          report("out_bytes", m_axis_tdata[77:64], want.nbytes);
      end
    end
  end

  // Receiver: after each result hold tready low for a random stall, possibly none.
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      draw = quiet ? 0 : $urandom_range(0, 9);
      stall_left <= draw;
      if (draw != 0) m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      if (stall_left > 1) stall_left <= stall_left - 1;
      else m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: give up when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every action, oversize and duplicate, with a short reveal.
  task automatic test_field_extremes();
    write_reg(1'b0, 20'd1);
    send_item(ACT_NONE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
    send_item(ACT_TAKE);
    send_item(ACT_TICK);
    send_item(ACT_ADD, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000, 14'd0);
    send_item(ACT_ADD, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 14'd8192);
    send_item(ACT_ADD, 8'h00, 32'h0000_0000, 16'h0000, 16'h1234, 14'd5);
    send_item(ACT_ADD, 8'h00, 32'h5555_AAAA, 16'hA5A5, 16'h5A5A, 14'd8193);
    send_item(ACT_ADD, 8'h00, 32'hAAAA_5555, 16'h5A5A, 16'hA5A5, 14'h3FFF);
    send_item(ACT_ADD, 8'hFF, 32'h0000_0010, 16'h0001, 16'h00FF, 14'h1555);
    send_item(ACT_TAKE);  // nothing revealed yet
    send_item(ACT_TICK);
    write_reg(1'b0, 20'd0);
    repeat (5) send_item(ACT_TAKE);
    // Release order is now fixed; anything at or below the last key is late.
    send_item(ACT_ADD, 8'h00, 32'h0000_0000, 16'h0000, 16'h0001, 14'd1);
    send_item(ACT_ADD, 8'hFF, 32'h0000_0010, 16'h0001, 16'h0002, 14'd2);
    send_item(ACT_ADD, 8'hFF, 32'h0000_0011, 16'h0000, 16'h0003, 14'd3);
    send_item(ACT_TAKE);
  endtask

  // Fill every store entry, then the two extra adds must be refused.
  task automatic test_store_full();
    write_reg(1'b0, 20'd0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(ACT_ADD, 8'hFF, 32'h0000_1000 + i, 16'(i), 16'($urandom), 14'($urandom_range(0, 8192)));
    send_item(ACT_TAKE);
    write_reg(1'b0, 20'd0);
    for (int i = 0; i < DEPTH + 1; i++) send_item(ACT_TAKE);
  endtask

  // Fill the source table, reject a new source, then let a purge free slots.
  task automatic test_source_purge();
    write_reg(1'b1, 20'd3);
    for (int s = 20; s < 26; s++)
      send_item(ACT_ADD, 8'(s), 32'h10, 16'h0, 16'(s), 14'd64);
    repeat (4) send_item(ACT_TICK);
    send_item(ACT_ADD, 8'd30, 32'h10, 16'h0, 16'h30, 14'd64);
    send_item(ACT_ADD, 8'd20, 32'h11, 16'h0, 16'h31, 14'd64);
    repeat (4) send_item(ACT_TICK);
    repeat (3) send_item(ACT_TAKE);
  endtask

  task automatic test_random_traffic(int n, logic [19:0] reveal, logic [19:0] purge);
    int sel;
    logic [7:0]  src;
    logic [31:0] seq;
    logic [15:0] blk;
    logic [13:0] nb;
    write_reg(1'b0, reveal);
    write_reg(1'b1, purge);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        src = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        if ($urandom_range(0, 19) == 0) seq = $urandom;
        else begin
          seq_cursor += $urandom_range(0, 2);
          seq = seq_cursor + $urandom_range(0, 8);
        end
        blk = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        nb  = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, MAX_BYTES));
        send_item(ACT_ADD, src, seq, blk, 16'($urandom), nb);
      end else if (sel < 72) send_item(ACT_TICK);
      else if (sel < 97) send_item(ACT_TAKE);
      else send_item(ACT_NONE, 8'($urandom), $urandom, 16'($urandom), 16'($urandom),
                     14'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    quiet = 1'b0;
    seq_cursor = 32'hFFFF_FF00;  // the cursor wraps early in the run
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_NONE;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    clear_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_store_full();
    test_source_purge();
    test_random_traffic(300, 20'd0, 20'd0);
    quiet = 1'b1;
    test_random_traffic(250, 20'd5, 20'd30);
    quiet = 1'b0;
    test_random_traffic(300, 20'd2, 20'd10);
    test_random_traffic(300, 20'd20, 20'd200);
    // Long delays last: frames added here never reveal within the run.
    test_random_traffic(250, 20'hFFFFF, 20'hFFFFF);
    drain();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
